[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/gdad_pkg.sv]
// Types, constants and calendar helpers for the date add block.
`default_nettype none

package gdad_pkg;

  localparam int OFFSET_WIDTH_DEF = 21;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;
  localparam int YEAR_MAX    = 9999;

  // Signed day count while walking months; holds +/- one 400-year cycle.
  localparam int WALK_W = 19;

  // Steps to reduce a 14-bit start year mod 400.
  localparam int MOD_STEPS = 6;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

  // Quotient bits of the cycle skip for a given offset width.
  function automatic int div_steps(input int w);
    return (w > 17) ? w - 16 : 1;
  endfunction

  // Width of the shifted cycle divisor.
  function automatic int div_width(input int w);
    return (w > 17) ? w + 2 : 19;
  endfunction

  // Signed width of the working year.
  function automatic int year_width(input int w);
    return ((w - 8 > 15) ? w - 8 : 15) + 2;
  endfunction

  function automatic int cnt_width(input int w);
    int n;
    n = (div_steps(w) > MOD_STEPS) ? div_steps(w) : MOD_STEPS;
    return $clog2(n);
  endfunction

  // 4/100/400 rule from the low year bits and the year mod 400.
  function automatic logic is_leap(input logic [1:0] ylo, input logic [8:0] ymod);
    logic century;
    century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
    return ((ylo == 2'd0) && !century) || (ymod == 9'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV,
    ST_FIX,
    ST_WALK
  } gdad_state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic div_step;
    logic day_fix;
    logic walk_step;
    logic out_load;
  } gdad_cmd_t;

  typedef struct packed {
    logic walk_done;
  } gdad_status_t;

endpackage

`default_nettype wire

[rtl/core/gdad_dp.sv]
// Datapath: cycle skip divider, year mod 400 reduction, month walker, output word.
`default_nettype none

module gdad_dp import gdad_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire                           clk,
  input  gdad_cmd_t                     cmd,
  output gdad_status_t                  status,
  input  wire                           action,
  input  wire        [YEAR_W-1:0]       start_year,
  input  wire        [MONTH_W-1:0]      start_month,
  input  wire        [DAY_W-1:0]        start_day,
  input  wire signed [OFFSET_WIDTH-1:0] day_offset,
  output logic       [YEAR_W-1:0]       result_year,
  output logic       [MONTH_W-1:0]      result_month,
  output logic       [DAY_W-1:0]        result_day,
  output logic                          out_of_range
);

  localparam int QB  = div_steps(OFFSET_WIDTH);
  localparam int DW  = div_width(OFFSET_WIDTH);
  localparam int ACW = DW + 1;
  localparam int YW  = year_width(OFFSET_WIDTH);

  localparam logic [DW-1:0]     DIV_INIT  = DW'(CYCLE_DAYS) << (QB - 1);
  localparam logic [YW-1:0]     YDEL_INIT = YW'(CYCLE_YEARS) << (QB - 1);
  localparam logic [YEAR_W-1:0] MSUB_INIT = YEAR_W'(CYCLE_YEARS) << (MOD_STEPS - 1);

  logic                     fwd;
  logic signed [ACW-1:0]    acc;
  logic        [DW-1:0]     divisor;
  logic        [YW-1:0]     ydel;
  logic signed [YW-1:0]     yr;
  logic        [YEAR_W-1:0] ymod;
  logic        [YEAR_W-1:0] msub;
  logic        [MONTH_W-1:0] mon;
  logic signed [WALK_W-1:0] day;

  // load
  logic                    neg;
  logic [OFFSET_WIDTH-1:0] off_u;
  logic [OFFSET_WIDTH-1:0] mag;
  logic                    fwd_in;
  logic signed [ACW-1:0]   mag_x;
  logic signed [ACW-1:0]   sd_x;
  logic [MONTH_W-1:0]      mon_in;

  assign off_u  = day_offset;
  assign neg    = off_u[OFFSET_WIDTH-1];
  assign mag    = neg ? (~off_u + 1'b1) : off_u;
  assign fwd_in = ~action ^ neg;
  assign mag_x  = $signed(ACW'(mag));
  assign sd_x   = $signed(ACW'(start_day));
  assign mon_in = (start_month == '0) ? MONTH_JAN :
                  (start_month > MONTH_DEC) ? MONTH_DEC : start_month;

  // cycle skip step
  logic signed [ACW-1:0] div_x;
  logic signed [ACW-1:0] acc_p1;
  logic signed [ACW-1:0] acc_neg;

  assign div_x   = $signed({1'b0, divisor});
  assign acc_p1  = acc + ACW'(1);
  assign acc_neg = -acc;

  // walk step
  logic [8:0] ym9;
  logic [8:0] ymod_prev;
  logic [8:0] ymod_succ;
  logic       leap_cur;
  logic       leap_prev;
  logic signed [WALK_W-1:0] ylen_cur;
  logic signed [WALK_W-1:0] ylen_prev;
  logic signed [WALK_W-1:0] mlen_cur;
  logic signed [WALK_W-1:0] mlen_back;
  logic       year_fwd;
  logic       year_back;
  logic       done;

  assign ym9       = ymod[8:0];
  assign ymod_prev = (ym9 == 9'd0) ? 9'(CYCLE_YEARS - 1) : ym9 - 9'd1;
  assign ymod_succ = (ym9 == 9'(CYCLE_YEARS - 1)) ? 9'd0 : ym9 + 9'd1;
  assign leap_cur  = is_leap(yr[1:0], ym9);
  assign leap_prev = is_leap(yr[1:0] - 2'd1, ymod_prev);
  assign ylen_cur  = leap_cur  ? WALK_W'(366) : WALK_W'(365);
  assign ylen_prev = leap_prev ? WALK_W'(366) : WALK_W'(365);
  assign mlen_cur  = $signed(WALK_W'(month_days(leap_cur, mon)));
  assign mlen_back = (mon == MONTH_JAN) ? WALK_W'(31) :
                     $signed(WALK_W'(month_days(leap_cur, mon - 4'd1)));

  // whole-year hops are only taken at January, where they equal twelve month steps
  assign year_fwd  = (mon == MONTH_JAN) && (day > ylen_cur);
  assign year_back = (mon == MONTH_JAN) && ((day + ylen_prev) < WALK_W'(1));
  assign done      = fwd ? !(day > mlen_cur) : !(day < WALK_W'(1));

  assign status.walk_done = done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fwd     <= fwd_in;
      acc     <= fwd_in ? (mag_x + sd_x - ACW'(1)) : (mag_x - sd_x);
      divisor <= DIV_INIT;
      ydel    <= YDEL_INIT;
      yr      <= $signed(YW'(start_year));
      ymod    <= start_year;
      msub    <= MSUB_INIT;
      mon     <= mon_in;
    end
    if (cmd.mod_step) begin
      if (ymod >= msub) begin
        ymod <= ymod - msub;
      end
      msub <= msub >> 1;
    end
    if (cmd.div_step) begin
      if (acc >= div_x) begin
        acc <= acc - div_x;
        yr  <= fwd ? (yr + $signed(ydel)) : (yr - $signed(ydel));
      end
      divisor <= divisor >> 1;
      ydel    <= ydel >> 1;
    end
    if (cmd.day_fix) begin
      day <= fwd ? acc_p1[WALK_W-1:0] : acc_neg[WALK_W-1:0];
    end
    if (cmd.walk_step && !done) begin
      if (fwd) begin
        if (year_fwd) begin
          day  <= day - ylen_cur;
          yr   <= yr + YW'(1);
          ymod <= YEAR_W'(ymod_succ);
        end else begin
          day <= day - mlen_cur;
          if (mon == MONTH_DEC) begin
            mon  <= MONTH_JAN;
            yr   <= yr + YW'(1);
            ymod <= YEAR_W'(ymod_succ);
          end else begin
            mon <= mon + 4'd1;
          end
        end
      end else begin
        if (year_back) begin
          day  <= day + ylen_prev;
          yr   <= yr - YW'(1);
          ymod <= YEAR_W'(ymod_prev);
        end else begin
          day <= day + mlen_back;
          if (mon == MONTH_JAN) begin
            mon  <= MONTH_DEC;
            yr   <= yr - YW'(1);
            ymod <= YEAR_W'(ymod_prev);
          end else begin
            mon <= mon - 4'd1;
          end
        end
      end
    end
    if (cmd.out_load) begin
      if (yr < YW'(1)) begin
        result_year  <= YEAR_W'(1);
        result_month <= MONTH_JAN;
        result_day   <= DAY_W'(1);
        out_of_range <= 1'b1;
      end else if (yr > YW'(YEAR_MAX)) begin
        result_year  <= YEAR_W'(YEAR_MAX);
        result_month <= MONTH_DEC;
        result_day   <= DAY_W'(31);
        out_of_range <= 1'b1;
      end else begin
        result_year  <= yr[YEAR_W-1:0];
        result_month <= mon;
        result_day   <= day[DAY_W-1:0];
        out_of_range <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/gdad_ctrl.sv]
// Controller: sequences load, mod 400, cycle skip, walk and output word handoff.
`default_nettype none
`include "assert_macros.svh"

module gdad_ctrl import gdad_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire          out_stall,
  output gdad_cmd_t    cmd,
  input  gdad_status_t status
);

  localparam int QB = div_steps(OFFSET_WIDTH);
  localparam int CW = cnt_width(OFFSET_WIDTH);

  gdad_state_t   state;
  gdad_state_t   state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt == CW'(MOD_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DIV;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CW'(QB - 1)) begin
          cnt_next   = '0;
          state_next = ST_FIX;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FIX: begin
        cmd.day_fix = 1'b1;
        state_next  = ST_WALK;
      end
      ST_WALK: begin
        if (!status.walk_done) begin
          cmd.walk_step = 1'b1;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_starts_mod, clk, rst, in_valid && !in_stall,
               state == ST_MOD && cnt == '0)
  `ASSERT_HOLDS(a_load_only_when_free, clk, rst,
                !cmd.out_load || (out_free && status.walk_done))
  `ASSERT_HOLDS(a_one_datapath_op, clk, rst,
                $onehot0({cmd.load, cmd.mod_step, cmd.div_step, cmd.day_fix, cmd.walk_step}))
  `ASSERT_NEXT(a_taken_word_clears, clk, rst, out_valid && !out_stall && !cmd.out_load,
               !out_valid)

endmodule

`default_nettype wire

[rtl/core/gregorian_date_add_days_top.sv]
// Top level of the Gregorian date plus/minus days block.
//
// Input channel: in_valid/in_stall carries one word (action, start date,
// signed day_offset). Output channel: out_valid/out_stall carries the
// resulting date and the out_of_range clamp flag, one word per input word.
// A negative offset flips the direction. Results outside years 1..9999 clamp
// to 0001-01-01 or 9999-12-31 with out_of_range set.
// Sequence: load, start year mod 400 reduction, cycle skip over Q quotient
// bits (Q = OFFSET_WIDTH-16, at least 1), day fix, then the walk, which
// takes one month step or one whole-year hop at January at a time until
// the day fits the month, then the output load.
// The walk loop sets the item time.
// One item is in flight at a time; in_stall is high from acceptance until
// the result is moved into the output register.
// The output register holds a word while out_stall is high; a finished
// result waits in the datapath until that register frees up, and the next
// input word may be accepted as soon as the result is handed over.
// rst is synchronous, active high: clears the controller and out_valid.
`default_nettype none

module gregorian_date_add_days_top import gdad_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           action,
  input  wire        [YEAR_W-1:0]       start_year,
  input  wire        [MONTH_W-1:0]      start_month,
  input  wire        [DAY_W-1:0]        start_day,
  input  wire signed [OFFSET_WIDTH-1:0] day_offset,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic       [YEAR_W-1:0]       result_year,
  output logic       [MONTH_W-1:0]      result_month,
  output logic       [DAY_W-1:0]        result_day,
  output logic                          out_of_range
);

  gdad_cmd_t    cmd;
  gdad_status_t status;

  gdad_ctrl #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  gdad_dp #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .action      (action),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .day_offset  (day_offset),
    .result_year (result_year),
    .result_month(result_month),
    .result_day  (result_day),
    .out_of_range(out_of_range)
  );

endmodule

`default_nettype wire
